[hw/rtl/dva_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dva_pkg: shared types and constants for the distance voice allocator
// Command and result word layouts, sequencer states, register indexes.
// ----------------------------------------------------------------------------
package dva_pkg;

	// Width of a coordinate as it arrives on the ports and config bus
	localparam int COORD_IN_W = 16;
	localparam int VOICE_IDX_W = 5;
	localparam int CFG_IDX_W = 2;

	// Command kinds
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Z = 2'd2;

	typedef struct packed {
		logic                           kind;
		logic signed [COORD_IN_W-1:0]   req_x;
		logic signed [COORD_IN_W-1:0]   req_y;
		logic signed [COORD_IN_W-1:0]   req_z;
		logic [VOICE_IDX_W-1:0]         release_index;
	} cmd_t;

	typedef struct packed {
		logic                   granted;
		logic [VOICE_IDX_W-1:0] voice_index;
		logic                   stolen;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SELF,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

endpackage : dva_pkg
`default_nettype wire

[hw/rtl/distance_voice_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distance_voice_allocator_unit: voice allocator with farthest-voice stealing
//
// Command channel: a word on cmd is taken at a clock edge where start is high
// and busy is low. A release word (kind 1) frees one voice in that same edge
// and gives no result. A request word (kind 0) starts a scan of the voice
// table in index order: the first idle voice is granted. When every voice
// plays, one shared distance pipeline (read, abs diff, square, sum/compare)
// measures each voice against the listener, one voice per cycle, and then
// the requester itself; the requester steals the farthest voice only if it
// is strictly closer.
// Result channel: done is high for exactly one cycle with the word on
// result; there is no backpressure, the receiver must take it then.
// Order: a request that finds idle voice k gives a registered done when the
// scan reaches k; a full table gives done after the one-voice-per-cycle pass,
// the three-stage distance pipeline, the sum/compare and a decide step.
// busy stays high for the whole request; a release never raises busy.
// The user must write listener registers on cfg_we only while the block is idle; the block itself does not enforce it.
// Reset marks every voice idle and clears the listener to the origin.
// ----------------------------------------------------------------------------
module distance_voice_allocator_unit
	import dva_pkg::*;
#(
	parameter int NUM_VOICES = 32,
	parameter int COORD_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire cmd_t                   cmd,
	output logic                        done,
	output result_t                     result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [COORD_IN_W-1:0]  cfg_data
);

	localparam int IW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CW  = COORD_BITS;
	localparam int SQW = 2 * CW;
	localparam int DW  = SQW + 2;
	localparam int PW  = 3 * CW;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_VOICES - 1);

	// Mask to COORD_BITS and zero extend from there
	function automatic logic [CW-1:0] to_coord(input logic [COORD_IN_W-1:0] v);
		to_coord = CW'({32'd0, v});
	endfunction

	// Absolute difference of two coordinates; always fits CW bits
	function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
		input logic [CW-1:0] b);
		logic [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		abs_diff = d[CW] ? CW'(-d) : CW'(d);
	endfunction

	state_t state_q, state_d;

	logic [IW-1:0]         idx_q;
	logic [NUM_VOICES-1:0] voice_busy_q;
	logic [COORD_IN_W-1:0] lis_x_q, lis_y_q, lis_z_q;
	logic [PW-1:0]         req_pos_q;
	logic [PW-1:0]         pos_mem [NUM_VOICES];

	logic [DW-1:0] far_q, own_q;
	logic [IW-1:0] far_idx_q;

	logic          done_q;
	result_t       res_q;

	// Distance pipeline registers
	logic [PW-1:0] rd_s1;
	logic          valid_s1, self_s1;
	logic [IW-1:0] idx_s1;
	logic [CW-1:0] ad_x_s2, ad_y_s2, ad_z_s2;
	logic          valid_s2, self_s2;
	logic [IW-1:0] idx_s2;
	logic [SQW-1:0] sq_x_s3, sq_y_s3, sq_z_s3;
	logic          valid_s3, self_s3;
	logic [IW-1:0] idx_s3;

	// Control decodes
	logic cmd_take, req_take, rel_take, rel_in_range;
	logic scan_hit, scan_issue, self_issue, decide, steal;
	logic issue;
	logic [PW-1:0] src_pos;
	logic [DW-1:0] dist_sum;
	logic [CW-1:0] lx, ly, lz;
	logic [IW-1:0] rel_idx;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = res_q;

	assign cmd_take = start && !busy;
	assign req_take = cmd_take && (cmd.kind == KIND_REQUEST);
	assign rel_take = cmd_take && (cmd.kind == KIND_RELEASE);
	assign rel_in_range = (9'(cmd.release_index) < 9'(NUM_VOICES));
	assign rel_idx = IW'(cmd.release_index);

	assign lx = to_coord(lis_x_q);
	assign ly = to_coord(lis_y_q);
	assign lz = to_coord(lis_z_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_take) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!voice_busy_q[idx_q]) state_d = ST_IDLE;
				else if (idx_q == LAST_IDX) state_d = ST_SELF;
			end
			ST_SELF: state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (valid_s3 && self_s3) state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		scan_hit   = 1'b0;
		scan_issue = 1'b0;
		self_issue = 1'b0;
		decide     = 1'b0;
		case (state_q)
			ST_SCAN: begin
				scan_hit   = !voice_busy_q[idx_q];
				scan_issue = voice_busy_q[idx_q];
			end
			ST_SELF:   self_issue = 1'b1;
			ST_DECIDE: decide = 1'b1;
			default: ;
		endcase
	end

	assign steal = decide && (own_q < far_q);
	assign issue = scan_issue || self_issue;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			voice_busy_q <= '0;
			lis_x_q      <= '0;
			lis_y_q      <= '0;
			lis_z_q      <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;

			if (req_take) idx_q <= '0;
			else if (scan_issue) idx_q <= idx_q + 1'b1;

			if (rel_take && rel_in_range) voice_busy_q[rel_idx] <= 1'b0;
			if (scan_hit) voice_busy_q[idx_q] <= 1'b1;

			if (cfg_we) begin
				case (cfg_index)
					CFG_LISTENER_X: lis_x_q <= cfg_data;
					CFG_LISTENER_Y: lis_y_q <= cfg_data;
					CFG_LISTENER_Z: lis_z_q <= cfg_data;
					default: ;
				endcase
			end

			// pipeline flushes whenever the sequencer is idle
			valid_s1 <= issue;
			valid_s2 <= valid_s1 && busy;
			valid_s3 <= valid_s2 && busy;

			done_q <= scan_hit || decide;
		end
	end

	// Position memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (scan_hit) pos_mem[idx_q] <= req_pos_q;
		else if (steal) pos_mem[far_idx_q] <= req_pos_q;
		rd_s1 <= pos_mem[idx_q];
	end

	assign src_pos = self_s1 ? req_pos_q : rd_s1;

	// Shared distance unit: abs diff, square, then sum
	always_ff @(posedge clk) begin
		self_s1 <= self_issue;
		idx_s1  <= idx_q;

		ad_x_s2 <= abs_diff(lx, src_pos[PW-1 -: CW]);
		ad_y_s2 <= abs_diff(ly, src_pos[2*CW-1 -: CW]);
		ad_z_s2 <= abs_diff(lz, src_pos[CW-1:0]);
		self_s2 <= self_s1;
		idx_s2  <= idx_s1;

		sq_x_s3 <= SQW'(ad_x_s2) * SQW'(ad_x_s2);
		sq_y_s3 <= SQW'(ad_y_s2) * SQW'(ad_y_s2);
		sq_z_s3 <= SQW'(ad_z_s2) * SQW'(ad_z_s2);
		self_s3 <= self_s2;
		idx_s3  <= idx_s2;
	end

	assign dist_sum = DW'(sq_x_s3) + DW'(sq_y_s3) + DW'(sq_z_s3);

	// Request capture, farthest tracking and result word
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_pos_q <= {to_coord(cmd.req_x), to_coord(cmd.req_y),
				to_coord(cmd.req_z)};
			far_q     <= '0;
			far_idx_q <= '0;
		end else if (valid_s3) begin
			if (self_s3) begin
				own_q <= dist_sum;
			end else if (dist_sum > far_q) begin
				far_q     <= dist_sum;
				far_idx_q <= idx_s3;
			end
		end

		if (scan_hit) begin
			res_q.granted     <= 1'b1;
			res_q.voice_index <= VOICE_IDX_W'(idx_q);
			res_q.stolen      <= 1'b0;
		end else if (decide) begin
			res_q.granted     <= steal;
			res_q.voice_index <= steal ? VOICE_IDX_W'(far_idx_q) : '0;
			res_q.stolen      <= steal;
		end
	end

endmodule : distance_voice_allocator_unit
`default_nettype wire

[tb/distance_voice_allocator_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_voice_allocator_unit_test: self-checking bench for the allocator
// Drives request and release words and listener register writes. A built-in
// voice table predicts every grant, steal and denial, and each result word is
// checked against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module distance_voice_allocator_unit_test;
	import dva_pkg::*;

	localparam int VOICES = 32;
	localparam int DRAIN_CYCLES = VOICES + 8;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_WORDS = 750;
	localparam int MAX_PRINTED = 50;
	// index 3 is not a register; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef logic signed [COORD_IN_W-1:0] coord_t;
	typedef enum int {SPOT_ANY, SPOT_EDGE, SPOT_NEAR, SPOT_GRID} spot_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	cmd_t                  cmd = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_LISTENER_X;
	logic [COORD_IN_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  done;
	result_t               result;

	distance_voice_allocator_unit #(
		.NUM_VOICES(VOICES),
		.COORD_BITS(COORD_IN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow voice table and listener
	logic    voice_on [VOICES];
	coord_t  voice_x [VOICES];
	coord_t  voice_y [VOICES];
	coord_t  voice_z [VOICES];
	coord_t  lis_x = '0;
	coord_t  lis_y = '0;
	coord_t  lis_z = '0;
	result_t grant_due [$];
	result_t due_word;

	int errors = 0;
	int words_sent = 0;
	int stall_cycles = 0;
	bit calm = 1'b0;

	initial begin
		for (int i = 0; i < VOICES; i++) voice_on[i] = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// exact squared distance to the listener
	function automatic longint span_sq(input coord_t px, input coord_t py, input coord_t pz);
		longint dx, dy, dz;
		dx = longint'(px) - longint'(lis_x);
		dy = longint'(py) - longint'(lis_y);
		dz = longint'(pz) - longint'(lis_z);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// first idle voice, else steal the farthest if strictly closer, else deny
	function automatic result_t allocate_voice(input coord_t rx, input coord_t ry,
			input coord_t rz);
		result_t r;
		longint  far_d, d;
		int      far_i;
		r = '0;
		far_d = 0;
		far_i = 0;
		for (int i = 0; i < VOICES; i++) begin
			if (!voice_on[i]) begin
				voice_on[i] = 1'b1;
				voice_x[i] = rx;
				voice_y[i] = ry;
				voice_z[i] = rz;
				r.granted = 1'b1;
				r.voice_index = VOICE_IDX_W'(i);
				return r;
			end
			d = span_sq(voice_x[i], voice_y[i], voice_z[i]);
			if (d > far_d) begin
				far_d = d;
				far_i = i;
			end
		end
		if (span_sq(rx, ry, rz) < far_d) begin
			voice_x[far_i] = rx;
			voice_y[far_i] = ry;
			voice_z[far_i] = rz;
			r.granted = 1'b1;
			r.voice_index = VOICE_IDX_W'(far_i);
			r.stolen = 1'b1;
		end
		return r;
	endfunction

	function automatic void apply_word(input cmd_t w);
		result_t due;
		if (w.kind == KIND_RELEASE) begin
			if (w.release_index < VOICES) voice_on[w.release_index] = 1'b0;
		end else begin
			due = allocate_voice(w.req_x, w.req_y, w.req_z);
			grant_due = {grant_due, due};
		end
	endfunction

	// send one word; returns at the accepting edge with start still high
	task automatic send_word(input cmd_t w);
		if (!calm && $urandom_range(99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		apply_word(w);
		words_sent++;
	endtask

	// unused fields carry random bits too
	function automatic cmd_t random_word();
		return cmd_t'({$urandom, $urandom});
	endfunction

	task automatic request_at(input coord_t x, input coord_t y, input coord_t z);
		cmd_t w;
		w = random_word();
		w.kind = KIND_REQUEST;
		w.req_x = x;
		w.req_y = y;
		w.req_z = z;
		send_word(w);
	endtask

	task automatic release_voice(input int idx);
		cmd_t w;
		w = random_word();
		w.kind = KIND_RELEASE;
		w.release_index = VOICE_IDX_W'(idx);
		send_word(w);
	endtask

	function automatic coord_t pick_coord(input spot_t s, input coord_t centre);
		int k;
		k = $urandom_range(4);
		case (s)
			SPOT_EDGE: begin
				case (k % 4)
					0: return coord_t'(16'sh8000);
					1: return coord_t'(16'sh7fff);
					2: return coord_t'(0);
					default: return coord_t'(-1);
				endcase
			end
			SPOT_NEAR: return centre + coord_t'(int'($urandom_range(16)) - 8);
			// coarse lattice around the listener gives many equal distances
			SPOT_GRID: return centre + coord_t'((k - 2) * 1000);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic request_spot(input spot_t s);
		request_at(pick_coord(s, lis_x), pick_coord(s, lis_y), pick_coord(s, lis_z));
	endtask

	// mostly a voice that plays, sometimes any index
	function automatic int pick_playing();
		int picks [$];
		for (int i = 0; i < VOICES; i++) if (voice_on[i]) picks = {picks, i};
		if (picks.size() == 0 || $urandom_range(9) == 0) return $urandom_range(VOICES - 1);
		return picks[$urandom_range(picks.size() - 1)];
	endfunction

	// drop start, wait for all results, then let the block go quiet
	task automatic settle();
		start <= 1'b0;
		while (grant_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input coord_t v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			CFG_LISTENER_X: lis_x = v;
			CFG_LISTENER_Y: lis_y = v;
			CFG_LISTENER_Z: lis_z = v;
			default: ;
		endcase
	endtask

	task automatic set_listener(input coord_t x, input coord_t y, input coord_t z);
		settle();
		reg_write(CFG_LISTENER_X, x);
		reg_write(CFG_SPARE, coord_t'($urandom));
		reg_write(CFG_LISTENER_Y, y);
		reg_write(CFG_LISTENER_Z, z);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	// idle-voice grants, extreme coordinates, releases of idle and busy voices
	task automatic test_first_grants();
		release_voice(7);
		request_at(16'sh7fff, 16'sh7fff, 16'sh7fff);
		request_at(16'sh8000, 16'sh8000, 16'sh8000);
		request_at(0, 0, 0);
		request_at(-1, 1, 16'sh8000);
		release_voice(1);
		request_at(16'sh7fff, 16'sh8000, -1);
		release_voice(31);
		release_voice(0);
		request_at(5, -5, 5);
	endtask

	// listener in a corner, requests at the opposite corner
	task automatic test_listener_corners();
		set_listener(16'sh8000, 16'sh7fff, 16'sh8000);
		request_at(16'sh7fff, 16'sh8000, 16'sh7fff);
		request_at(16'sh8000, 16'sh7fff, 16'sh8000);
		request_spot(SPOT_EDGE);
		set_listener(16'sh7fff, 16'sh8000, 16'sh7fff);
		request_spot(SPOT_NEAR);
		request_spot(SPOT_EDGE);
		set_listener(0, 0, 0);
	endtask

	// mostly requests, so the table stays full and steals and denials happen
	task automatic test_churn(input int n);
		repeat (n) begin
			if ($urandom_range(99) < 18) release_voice(pick_playing());
			else request_spot(spot_t'($urandom_range(3)));
		end
	endtask

	// every voice parked on the listener: nothing can be closer
	task automatic test_crowd_at_listener();
		for (int i = 0; i < VOICES; i++) if (voice_on[i]) release_voice(i);
		repeat (VOICES) request_at(lis_x, lis_y, lis_z);
		repeat (3) request_spot(SPOT_ANY);
		request_at(lis_x, lis_y, lis_z);
	endtask

	// lattice positions: equal farthest distances, lowest index must win
	task automatic test_tied_distances(input int n);
		repeat (n) begin
			if ($urandom_range(99) < 15) release_voice(pick_playing());
			else request_spot(SPOT_GRID);
		end
	endtask

	task automatic test_listener_sweep();
		set_listener(pick_coord(spot_t'($urandom_range(1)), '0),
				pick_coord(spot_t'($urandom_range(1)), '0),
				pick_coord(spot_t'($urandom_range(1)), '0));
		test_churn($urandom_range(10, 30));
	endtask

	// ---------------------------------------------------------------- checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (grant_due.size() == 0) begin
				report_mismatch("result word with no request outstanding");
			end else begin
				due_word = grant_due.pop_front();
				if (result.granted !== due_word.granted)
					report_mismatch($sformatf("granted %b, want %b",
							result.granted, due_word.granted));
				if (result.voice_index !== due_word.voice_index)
					report_mismatch($sformatf("voice_index %0d, want %0d",
							result.voice_index, due_word.voice_index));
				if (result.stolen !== due_word.stolen)
					report_mismatch($sformatf("stolen %b, want %b",
							result.stolen, due_word.stolen));
			end
		end
	end

	// watchdog: cycles without any word moving
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main
	initial begin
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_grants();
		test_listener_corners();

		while (words_sent < RANDOM_WORDS) begin
			calm = (words_sent >= 300 && words_sent < 450);
			pick = $urandom_range(99);
			if (pick < 55) test_churn($urandom_range(20, 60));
			else if (pick < 70) test_tied_distances($urandom_range(20, 50));
			else if (pick < 80) test_crowd_at_listener();
			else test_listener_sweep();
		end

		settle();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/dva_pkg.sv
hw/rtl/distance_voice_allocator_unit.sv
tb/distance_voice_allocator_unit_test.sv
